[rtl/csl_pkg.sv]
// ----------------------------------------------------------------------------
// csl_pkg: shared types and constants of the c subset lexer
// token kinds and codes, scanner modes, character classes and keyword table
// ----------------------------------------------------------------------------
package csl_pkg;

    localparam int LENGTH_BITS_DEF = 16;
    localparam int LINE_BITS_DEF   = 24;
    localparam int OFFSET_BITS     = 32;
    localparam int QUEUE_DEPTH     = 4;
    localparam int WORD_BITS       = 48;
    localparam int KW_COUNT        = 6;

    typedef enum logic [2:0] {
        KIND_IDENT   = 3'd0,
        KIND_KEYWORD = 3'd1,
        KIND_NUMBER  = 3'd2,
        KIND_OP      = 3'd3,
        KIND_SEP     = 3'd4,
        KIND_COMMENT = 3'd5,
        KIND_UNKNOWN = 3'd6,
        KIND_END     = 3'd7
    } kind_t;

    typedef enum logic [3:0] {
        MODE_IDLE     = 4'd0,
        MODE_IDENT    = 4'd1,
        MODE_NUM_INT  = 4'd2,
        MODE_NUM_DOT  = 4'd3,
        MODE_NUM_FRAC = 4'd4,
        MODE_SLASH    = 4'd5,
        MODE_EQ       = 4'd6,
        MODE_LINE_C   = 4'd7,
        MODE_BLOCK_C  = 4'd8
    } mode_t;

    // operator codes
    localparam logic [2:0] OP_PLUS   = 3'd0;
    localparam logic [2:0] OP_MINUS  = 3'd1;
    localparam logic [2:0] OP_STAR   = 3'd2;
    localparam logic [2:0] OP_SLASH  = 3'd3;
    localparam logic [2:0] OP_ASSIGN = 3'd4;
    localparam logic [2:0] OP_EQUAL  = 3'd5;
    localparam logic [2:0] OP_LESS   = 3'd6;
    localparam logic [2:0] OP_GREAT  = 3'd7;

    // separator codes
    localparam logic [2:0] SEP_LPAREN = 3'd0;
    localparam logic [2:0] SEP_RPAREN = 3'd1;
    localparam logic [2:0] SEP_LBRACE = 3'd2;
    localparam logic [2:0] SEP_RBRACE = 3'd3;
    localparam logic [2:0] SEP_SEMI   = 3'd4;
    localparam logic [2:0] SEP_COMMA  = 3'd5;

    localparam logic [2:0] CODE_NONE = 3'd0;

    // record bundle bookkeeping
    localparam int SLOT_COUNT = 3;
    localparam int SLOT_CNT_W = 2;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {[8'h61:8'h7a], [8'h41:8'h5a], 8'h5f});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {[8'h30:8'h39]});
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c inside {8'h20, 8'h09, 8'h0d});
    endfunction

    // keyword text, right aligned, index equals keyword code
    function automatic logic [WORD_BITS-1:0] kw_text(input logic [2:0] idx);
        logic [WORD_BITS-1:0] t;
        case (idx)
            3'd0:    t = 48'h0000_0069_6E74;
            3'd1:    t = 48'h0066_6C6F_6174;
            3'd2:    t = 48'h0000_0000_6966;
            3'd3:    t = 48'h0000_656C_7365;
            3'd4:    t = 48'h0077_6869_6C65;
            3'd5:    t = 48'h7265_7475_726E;
            default: t = '1;
        endcase
        return t;
    endfunction

    function automatic logic [2:0] kw_len(input logic [2:0] idx);
        logic [2:0] n;
        case (idx)
            3'd0:    n = 3'd3;
            3'd1:    n = 3'd5;
            3'd2:    n = 3'd2;
            3'd3:    n = 3'd4;
            3'd4:    n = 3'd5;
            3'd5:    n = 3'd6;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

[rtl/c_subset_lexer_core.sv]
// ----------------------------------------------------------------------------
// c_subset_lexer_core: streaming lexer for a small c subset
// source bytes in, token records (kind, code, length, offset, line) out
// ----------------------------------------------------------------------------
// usage
//   input side is a queue: drive char_byte/end_mark with push, a transaction
//   completes on a clock edge with push high and full low
//   output side is a queue: while empty is low the oldest record sits on the
//   token ports, a transaction completes on an edge with pop high and empty low
//   each byte yields zero to three records, last_of_run marks the final one
//   end_mark flushes the pending token, emits the end record and restarts
//   offsets at 0 and the line count at 1
// timing
//   one byte accepted every cycle while the bundle queue has room; the scanner
//   decides combinationally and writes a bundle of up to three records into a
//   four-entry bundle queue
//   the first record of a byte passes through the bundle queue and the output
//   register to the ports; the rest follow one per cycle while pop is high
//   tokens still open wait until a later byte or end_mark closes them
//   when the receiver stalls, the queue fills and full rises; nothing is lost
// reset
//   rst_n clears scanner state, queue and the valid flag of the output register
// ----------------------------------------------------------------------------
module c_subset_lexer_core #(
    parameter int LENGTH_BITS = csl_pkg::LENGTH_BITS_DEF,
    parameter int LINE_BITS   = csl_pkg::LINE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      char_byte,
    input  logic                            end_mark,
    output logic                            empty,
    input  logic                            pop,
    output logic [2:0]                      token_kind,
    output logic [2:0]                      token_code,
    output logic [LENGTH_BITS-1:0]          token_length,
    output logic [csl_pkg::OFFSET_BITS-1:0] start_offset,
    output logic [LINE_BITS-1:0]            line_number,
    output logic                            last_of_run
);

    // one record: kind, code, length, start offset
    localparam int REC_W    = 6 + LENGTH_BITS + csl_pkg::OFFSET_BITS;
    // bundle: line, three record slots, record count
    localparam int BUNDLE_W = LINE_BITS + csl_pkg::SLOT_COUNT * REC_W + csl_pkg::SLOT_CNT_W;

    logic                accept;
    logic                q_push, q_pop, q_full, q_empty;
    logic [BUNDLE_W-1:0] q_wr_data, q_rd_data;

    assign full   = q_full;
    assign accept = push && !q_full;

    // front: scanner
    csl_front #(
        .LENGTH_BITS (LENGTH_BITS),
        .LINE_BITS   (LINE_BITS),
        .REC_W       (REC_W),
        .BUNDLE_W    (BUNDLE_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .char_byte   (char_byte),
        .end_mark    (end_mark),
        .bundle_push (q_push),
        .bundle_data (q_wr_data)
    );

    // bundle queue between scanner and serializer
    csl_queue #(
        .WIDTH   (BUNDLE_W),
        .DEPTH   (csl_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    // back: serializer and output register
    csl_back #(
        .LENGTH_BITS  (LENGTH_BITS),
        .LINE_BITS    (LINE_BITS),
        .REC_W        (REC_W),
        .BUNDLE_W     (BUNDLE_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .bundle_data  (q_rd_data),
        .bundle_empty (q_empty),
        .bundle_pop   (q_pop),
        .pop          (pop),
        .empty        (empty),
        .token_kind   (token_kind),
        .token_code   (token_code),
        .token_length (token_length),
        .start_offset (start_offset),
        .line_number  (line_number),
        .last_of_run  (last_of_run)
    );

    // an idle output register refills as soon as a bundle waits
    a_refill: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !q_empty) |=> !empty)
        else $error("output register did not pick up a waiting bundle");

    // bundles written to the queue always carry at least one record
    a_no_blank_bundle: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_wr_data[csl_pkg::SLOT_CNT_W-1:0] != '0))
        else $error("bundle with no records written to queue");

    // draining the last record with nothing queued leaves the output empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && q_empty) |=> empty)
        else $error("record appeared with no bundle queued");

endmodule

[rtl/csl_queue.sv]
// ----------------------------------------------------------------------------
// csl_queue: short register queue
// decouples the scanner from the record serializer, one push and one pop a cycle
// ----------------------------------------------------------------------------
module csl_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = csl_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/csl_front.sv]
// ----------------------------------------------------------------------------
// csl_front: byte scanner
// classifies one accepted byte a cycle and packs the records it ends into one bundle
// ----------------------------------------------------------------------------
module csl_front #(
    parameter int LENGTH_BITS = csl_pkg::LENGTH_BITS_DEF,
    parameter int LINE_BITS   = csl_pkg::LINE_BITS_DEF,
    parameter int REC_W       = 6 + LENGTH_BITS + csl_pkg::OFFSET_BITS,
    parameter int BUNDLE_W    = LINE_BITS + csl_pkg::SLOT_COUNT * REC_W
                                + csl_pkg::SLOT_CNT_W
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          char_byte,
    input  logic                end_mark,
    output logic                bundle_push,
    output logic [BUNDLE_W-1:0] bundle_data
);

    localparam int OFS_W = csl_pkg::OFFSET_BITS;
    localparam int WRD_W = csl_pkg::WORD_BITS;

    csl_pkg::mode_t         mode_reg, mode_next;
    logic                   star_reg, star_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [OFS_W-1:0]       pos_reg, pos_next;
    logic [OFS_W-1:0]       start_reg, start_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;
    logic [WRD_W-1:0]       word_reg, word_next;
    logic                   long_reg, long_next;

    logic [LENGTH_BITS-1:0] count_inc, count_inc2;
    logic [LINE_BITS-1:0]   line_inc;
    logic                   kw_hit;
    logic [2:0]             kw_idx;

    logic [2:0]             p0_kind, p0_code, s2_kind, s2_code;
    logic [LENGTH_BITS-1:0] p0_len, s2_len;
    logic [OFS_W-1:0]       s2_start;
    logic                   p0_v, p1_v, s2_v, redo;
    logic [REC_W-1:0]       rec_p0, rec_p1, rec_s2;
    logic [1:0]             slot_cnt;

    assign count_inc  = (count_reg == '1) ? count_reg : count_reg + 1'b1;
    assign count_inc2 = (count_inc == '1) ? count_inc : count_inc + 1'b1;
    assign line_inc   = (line_reg == '1) ? line_reg : line_reg + 1'b1;

    // keyword lookup on the buffered word
    always_comb
    begin
        kw_hit = 1'b0;
        kw_idx = 3'd0;
        for (int i = 0; i < csl_pkg::KW_COUNT; i++)
        begin
            if (!long_reg && count_reg == LENGTH_BITS'(csl_pkg::kw_len(3'(i)))
                && word_reg == csl_pkg::kw_text(3'(i)))
            begin
                kw_hit = 1'b1;
                kw_idx = 3'(i);
            end
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        star_next  = star_reg;
        line_next  = line_reg;
        pos_next   = pos_reg + 1'b1;
        start_next = start_reg;
        count_next = count_reg;
        word_next  = word_reg;
        long_next  = long_reg;
        p0_v       = 1'b0;
        p1_v       = 1'b0;
        s2_v       = 1'b0;
        redo       = 1'b0;
        s2_kind    = csl_pkg::KIND_UNKNOWN;
        s2_code    = csl_pkg::CODE_NONE;
        s2_len     = LENGTH_BITS'(1);
        s2_start   = pos_reg;

        // record of the pending token
        case (mode_reg)
            csl_pkg::MODE_IDENT:
            begin
                p0_kind = kw_hit ? csl_pkg::KIND_KEYWORD : csl_pkg::KIND_IDENT;
                p0_code = kw_hit ? kw_idx : csl_pkg::CODE_NONE;
                p0_len  = count_reg;
            end
            csl_pkg::MODE_NUM_INT, csl_pkg::MODE_NUM_DOT, csl_pkg::MODE_NUM_FRAC:
            begin
                p0_kind = csl_pkg::KIND_NUMBER;
                p0_code = csl_pkg::CODE_NONE;
                p0_len  = count_reg;
            end
            csl_pkg::MODE_SLASH:
            begin
                p0_kind = csl_pkg::KIND_OP;
                p0_code = csl_pkg::OP_SLASH;
                p0_len  = LENGTH_BITS'(1);
            end
            csl_pkg::MODE_EQ:
            begin
                p0_kind = csl_pkg::KIND_OP;
                p0_code = csl_pkg::OP_ASSIGN;
                p0_len  = LENGTH_BITS'(1);
            end
            default:
            begin
                p0_kind = csl_pkg::KIND_COMMENT;
                p0_code = csl_pkg::CODE_NONE;
                p0_len  = count_reg;
            end
        endcase

        if (end_mark)
        begin
            // flush, end record, back to reset state
            p0_v       = (mode_reg != csl_pkg::MODE_IDLE);
            p1_v       = (mode_reg == csl_pkg::MODE_NUM_DOT);
            s2_v       = 1'b1;
            s2_kind    = csl_pkg::KIND_END;
            s2_len     = '0;
            mode_next  = csl_pkg::MODE_IDLE;
            star_next  = 1'b0;
            line_next  = LINE_BITS'(1);
            pos_next   = '0;
            start_next = '0;
            count_next = '0;
            word_next  = '0;
            long_next  = 1'b0;
        end
        else
        begin
            case (mode_reg)
                csl_pkg::MODE_IDENT:
                begin
                    if (csl_pkg::is_alpha(char_byte) || csl_pkg::is_digit(char_byte))
                    begin
                        if (count_reg < LENGTH_BITS'(6))
                        begin
                            word_next = {word_reg[WRD_W-9:0], char_byte};
                        end
                        else
                        begin
                            long_next = 1'b1;
                        end
                        count_next = count_inc;
                    end
                    else
                    begin
                        p0_v = 1'b1;
                        redo = 1'b1;
                    end
                end
                csl_pkg::MODE_NUM_INT:
                begin
                    if (csl_pkg::is_digit(char_byte))
                    begin
                        count_next = count_inc;
                    end
                    else if (char_byte == 8'h2e)
                    begin
                        mode_next = csl_pkg::MODE_NUM_DOT;
                    end
                    else
                    begin
                        p0_v = 1'b1;
                        redo = 1'b1;
                    end
                end
                csl_pkg::MODE_NUM_DOT:
                begin
                    if (csl_pkg::is_digit(char_byte))
                    begin
                        count_next = count_inc2;
                        mode_next  = csl_pkg::MODE_NUM_FRAC;
                    end
                    else
                    begin
                        p0_v = 1'b1;
                        p1_v = 1'b1;
                        redo = 1'b1;
                    end
                end
                csl_pkg::MODE_NUM_FRAC:
                begin
                    if (csl_pkg::is_digit(char_byte))
                    begin
                        count_next = count_inc;
                    end
                    else
                    begin
                        p0_v = 1'b1;
                        redo = 1'b1;
                    end
                end
                csl_pkg::MODE_SLASH:
                begin
                    if (char_byte == 8'h2f)
                    begin
                        count_next = count_inc;
                        mode_next  = csl_pkg::MODE_LINE_C;
                    end
                    else if (char_byte == 8'h2a)
                    begin
                        count_next = count_inc;
                        star_next  = 1'b0;
                        mode_next  = csl_pkg::MODE_BLOCK_C;
                    end
                    else
                    begin
                        p0_v = 1'b1;
                        redo = 1'b1;
                    end
                end
                csl_pkg::MODE_EQ:
                begin
                    p0_v = 1'b1;
                    if (char_byte == 8'h3d)
                    begin
                        p0_code   = csl_pkg::OP_EQUAL;
                        p0_len    = LENGTH_BITS'(2);
                        mode_next = csl_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        redo = 1'b1;
                    end
                end
                csl_pkg::MODE_LINE_C:
                begin
                    if (char_byte == 8'h0a)
                    begin
                        p0_v = 1'b1;
                        redo = 1'b1;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                csl_pkg::MODE_BLOCK_C:
                begin
                    count_next = count_inc;
                    if (char_byte == 8'h2f && star_reg)
                    begin
                        p0_v      = 1'b1;
                        p0_len    = count_inc;
                        mode_next = csl_pkg::MODE_IDLE;
                        star_next = 1'b0;
                    end
                    else
                    begin
                        if (char_byte == 8'h0a)
                        begin
                            line_next = line_inc;
                        end
                        star_next = (char_byte == 8'h2a);
                    end
                end
                default:
                begin
                    redo = 1'b1;
                end
            endcase

            // byte handled from the idle state
            if (redo)
            begin
                mode_next = csl_pkg::MODE_IDLE;
                if (csl_pkg::is_blank(char_byte))
                begin
                    s2_v = 1'b0;
                end
                else if (char_byte == 8'h0a)
                begin
                    line_next = line_inc;
                end
                else if (csl_pkg::is_alpha(char_byte))
                begin
                    mode_next  = csl_pkg::MODE_IDENT;
                    start_next = pos_reg;
                    count_next = LENGTH_BITS'(1);
                    word_next  = WRD_W'(char_byte);
                    long_next  = 1'b0;
                end
                else if (csl_pkg::is_digit(char_byte))
                begin
                    mode_next  = csl_pkg::MODE_NUM_INT;
                    start_next = pos_reg;
                    count_next = LENGTH_BITS'(1);
                end
                else if (char_byte == 8'h2f)
                begin
                    mode_next  = csl_pkg::MODE_SLASH;
                    start_next = pos_reg;
                    count_next = LENGTH_BITS'(1);
                end
                else if (char_byte == 8'h3d)
                begin
                    mode_next  = csl_pkg::MODE_EQ;
                    start_next = pos_reg;
                    count_next = LENGTH_BITS'(1);
                end
                else
                begin
                    s2_v = 1'b1;
                    case (char_byte)
                        8'h2b:   begin s2_kind = csl_pkg::KIND_OP;  s2_code = csl_pkg::OP_PLUS;    end
                        8'h2d:   begin s2_kind = csl_pkg::KIND_OP;  s2_code = csl_pkg::OP_MINUS;   end
                        8'h2a:   begin s2_kind = csl_pkg::KIND_OP;  s2_code = csl_pkg::OP_STAR;    end
                        8'h3c:   begin s2_kind = csl_pkg::KIND_OP;  s2_code = csl_pkg::OP_LESS;    end
                        8'h3e:   begin s2_kind = csl_pkg::KIND_OP;  s2_code = csl_pkg::OP_GREAT;   end
                        8'h28:   begin s2_kind = csl_pkg::KIND_SEP; s2_code = csl_pkg::SEP_LPAREN; end
                        8'h29:   begin s2_kind = csl_pkg::KIND_SEP; s2_code = csl_pkg::SEP_RPAREN; end
                        8'h7b:   begin s2_kind = csl_pkg::KIND_SEP; s2_code = csl_pkg::SEP_LBRACE; end
                        8'h7d:   begin s2_kind = csl_pkg::KIND_SEP; s2_code = csl_pkg::SEP_RBRACE; end
                        8'h3b:   begin s2_kind = csl_pkg::KIND_SEP; s2_code = csl_pkg::SEP_SEMI;   end
                        8'h2c:   begin s2_kind = csl_pkg::KIND_SEP; s2_code = csl_pkg::SEP_COMMA;  end
                        default: begin s2_kind = csl_pkg::KIND_UNKNOWN; s2_code = csl_pkg::CODE_NONE; end
                    endcase
                end
            end
        end
    end

    // compact the valid records to the low slots, a dot record implies a number
    assign rec_p0 = {p0_kind, p0_code, p0_len, start_reg};
    assign rec_p1 = {3'(csl_pkg::KIND_UNKNOWN), csl_pkg::CODE_NONE, LENGTH_BITS'(1),
                     pos_reg - 1'b1};
    assign rec_s2 = {s2_kind, s2_code, s2_len, s2_start};
    assign slot_cnt = 2'(p0_v) + 2'(p1_v) + 2'(s2_v);

    assign bundle_data = {line_reg, rec_s2, (p1_v ? rec_p1 : rec_s2),
                          (p0_v ? rec_p0 : rec_s2), slot_cnt};
    assign bundle_push = accept && (slot_cnt != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= csl_pkg::MODE_IDLE;
            star_reg  <= 1'b0;
            line_reg  <= LINE_BITS'(1);
            pos_reg   <= '0;
            start_reg <= '0;
            count_reg <= '0;
            word_reg  <= '0;
            long_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            star_reg  <= star_next;
            line_reg  <= line_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            count_reg <= count_next;
            word_reg  <= word_next;
            long_reg  <= long_next;
        end
    end

endmodule

[rtl/csl_back.sv]
// ----------------------------------------------------------------------------
// csl_back: record serializer
// walks the records of the head bundle into the free output register, one a cycle
// ----------------------------------------------------------------------------
module csl_back #(
    parameter int LENGTH_BITS = csl_pkg::LENGTH_BITS_DEF,
    parameter int LINE_BITS   = csl_pkg::LINE_BITS_DEF,
    parameter int REC_W       = 6 + LENGTH_BITS + csl_pkg::OFFSET_BITS,
    parameter int BUNDLE_W    = LINE_BITS + csl_pkg::SLOT_COUNT * REC_W
                                + csl_pkg::SLOT_CNT_W
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [BUNDLE_W-1:0]             bundle_data,
    input  logic                            bundle_empty,
    output logic                            bundle_pop,
    input  logic                            pop,
    output logic                            empty,
    output logic [2:0]                      token_kind,
    output logic [2:0]                      token_code,
    output logic [LENGTH_BITS-1:0]          token_length,
    output logic [csl_pkg::OFFSET_BITS-1:0] start_offset,
    output logic [LINE_BITS-1:0]            line_number,
    output logic                            last_of_run
);

    localparam int CW = csl_pkg::SLOT_CNT_W;

    logic [1:0]           idx_reg, idx_next;
    logic                 valid_reg, valid_next;
    logic [REC_W-1:0]     rec_reg, rec_sel;
    logic [LINE_BITS-1:0] line_reg;
    logic                 last_reg, last_sel;
    logic [1:0]           slot_cnt;
    logic                 load;

    assign slot_cnt = bundle_data[CW-1:0];
    assign load     = !valid_reg || pop;

    always_comb
    begin
        case (idx_reg)
            2'd0:    rec_sel = bundle_data[CW +: REC_W];
            2'd1:    rec_sel = bundle_data[CW + REC_W +: REC_W];
            default: rec_sel = bundle_data[CW + 2*REC_W +: REC_W];
        endcase
    end

    assign last_sel = (idx_reg + 2'd1 == slot_cnt);

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        bundle_pop = 1'b0;
        if (load)
        begin
            valid_next = !bundle_empty;
            if (!bundle_empty)
            begin
                if (last_sel)
                begin
                    idx_next   = 2'd0;
                    bundle_pop = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !bundle_empty)
        begin
            rec_reg  <= rec_sel;
            line_reg <= bundle_data[BUNDLE_W-1 -: LINE_BITS];
            last_reg <= last_sel;
        end
    end

    assign empty        = !valid_reg;
    assign token_kind   = rec_reg[REC_W-1 -: 3];
    assign token_code   = rec_reg[REC_W-4 -: 3];
    assign token_length = rec_reg[csl_pkg::OFFSET_BITS +: LENGTH_BITS];
    assign start_offset = rec_reg[csl_pkg::OFFSET_BITS-1:0];
    assign line_number  = line_reg;
    assign last_of_run  = last_reg;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the c subset lexer core
// streams short c-like sources byte by byte into the core, predicts every token
// record with a behavioral lexer kept inside the bench and compares each popped
// record field by field, under random sender and receiver idling
// ----------------------------------------------------------------------------
module tb_top;

    // run control
    // slowest correct run: under 310 bytes, at most three records each, popped at
    // a third of full rate plus one hold-off; the limit leaves a wide margin
    localparam int CYCLE_LIMIT      = 40000;
    localparam int HOLD_AT          = 60;     // bytes taken before the long hold-off
    localparam int HOLD_CYCLES      = 120;
    localparam int DRAIN_CYCLES     = 16;     // covers the output register plus the queue
    localparam int RANDOM_PER_PHASE = 84;
    localparam int PRINT_CAP        = 40;

    // keyword codes
    localparam logic [2:0] KW_INT    = 3'd0;
    localparam logic [2:0] KW_FLOAT  = 3'd1;
    localparam logic [2:0] KW_IF     = 3'd2;
    localparam logic [2:0] KW_ELSE   = 3'd3;
    localparam logic [2:0] KW_WHILE  = 3'd4;
    localparam logic [2:0] KW_RETURN = 3'd5;

    // control characters
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
    } src_byte_t;

    typedef struct {
        csl_pkg::kind_t kind;
        logic [2:0]     code;
        logic [15:0]    len;
        logic [31:0]    offset;
        logic [23:0]    line;
        logic           last;
    } token_rec_t;

    // ------------------------------------------------------------------------
    // core ports, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        push      = 1'b0;
    logic [7:0]  char_byte = 8'h00;
    logic        end_mark  = 1'b0;
    logic        pop       = 1'b0;
    logic        full;
    logic        empty;
    logic [2:0]  token_kind;
    logic [2:0]  token_code;
    logic [15:0] token_length;
    logic [31:0] start_offset;
    logic [23:0] line_number;
    logic        last_of_run;

    c_subset_lexer_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .char_byte    (char_byte),
        .end_mark     (end_mark),
        .empty        (empty),
        .pop          (pop),
        .token_kind   (token_kind),
        .token_code   (token_code),
        .token_length (token_length),
        .start_offset (start_offset),
        .line_number  (line_number),
        .last_of_run  (last_of_run)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    src_byte_t  source_q[$];     // bytes waiting for the driver
    token_rec_t token_store[$];  // predicted records, oldest first
    token_rec_t run_recs[$];     // records produced by the byte being lexed
    src_byte_t  next_src;
    token_rec_t want_rec;

    int mismatches   = 0;
    int records_seen = 0;
    int bytes_taken  = 0;
    int cycle_cnt    = 0;
    int tx_idle_pct  = 22;
    int rx_idle_pct  = 67;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    string kw_words[6] = '{"int", "float", "if", "else", "while", "return"};

    // ------------------------------------------------------------------------
    // lexer prediction state
    // ------------------------------------------------------------------------
    csl_pkg::mode_t scan_state;
    logic           star_pending;   // last byte inside a block comment was '*'
    logic [23:0]    line_cnt;
    logic [31:0]    byte_pos;
    logic [31:0]    tok_start;
    logic [15:0]    tok_len;
    logic [47:0]    word_buf;       // first six characters of a word, right aligned
    logic           word_long;

    function automatic bit letter_char(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit digit_char(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void reset_scanner();
        scan_state   = csl_pkg::MODE_IDLE;
        star_pending = 1'b0;
        line_cnt     = 24'd1;
        byte_pos     = 32'd0;
        tok_start    = 32'd0;
        tok_len      = 16'd0;
        word_buf     = 48'd0;
        word_long    = 1'b0;
    endfunction

    // record carries the line count at the moment it is produced
    function automatic void note_token(csl_pkg::kind_t k, logic [2:0] code,
                                       logic [15:0] len, logic [31:0] at);
        token_rec_t r;
        r.kind   = k;
        r.code   = code;
        r.len    = len;
        r.offset = at;
        r.line   = line_cnt;
        r.last   = 1'b0;
        run_recs.insert(run_recs.size(), r);
    endfunction

    // length and line count both stick at their maximum
    function automatic void bump_len();
        if (tok_len != 16'hFFFF)
            tok_len = tok_len + 16'd1;
    endfunction

    function automatic void bump_line();
        if (line_cnt != 24'hFFFFFF)
            line_cnt = line_cnt + 24'd1;
    endfunction

    function automatic void open_token(csl_pkg::mode_t m, logic [31:0] at);
        scan_state = m;
        tok_start  = at;
        tok_len    = 16'd1;
    endfunction

    // words of seven or more characters never match a keyword
    function automatic void close_word();
        logic [2:0] kw;
        logic       hit;
        kw  = KW_INT;
        hit = !word_long;
        case (word_buf)
            "int":    kw = KW_INT;
            "float":  kw = KW_FLOAT;
            "if":     kw = KW_IF;
            "else":   kw = KW_ELSE;
            "while":  kw = KW_WHILE;
            "return": kw = KW_RETURN;
            default:  hit = 1'b0;
        endcase
        if (hit)
            note_token(csl_pkg::KIND_KEYWORD, kw, tok_len, tok_start);
        else
            note_token(csl_pkg::KIND_IDENT, csl_pkg::CODE_NONE, tok_len, tok_start);
    endfunction

    // byte seen with no token open
    function automatic void fresh_byte(logic [7:0] c, logic [31:0] at);
        scan_state = csl_pkg::MODE_IDLE;
        if (c == CH_SPACE || c == CH_TAB || c == CH_CR)
            return;
        if (c == CH_LF)
        begin
            bump_line();
            return;
        end
        if (letter_char(c))
        begin
            open_token(csl_pkg::MODE_IDENT, at);
            word_buf  = {40'd0, c};
            word_long = 1'b0;
            return;
        end
        if (digit_char(c))
        begin
            open_token(csl_pkg::MODE_NUM_INT, at);
            return;
        end
        case (c)
            "/":     open_token(csl_pkg::MODE_SLASH, at);
            "=":     open_token(csl_pkg::MODE_EQ, at);
            "+":     note_token(csl_pkg::KIND_OP, csl_pkg::OP_PLUS, 16'd1, at);
            "-":     note_token(csl_pkg::KIND_OP, csl_pkg::OP_MINUS, 16'd1, at);
            "*":     note_token(csl_pkg::KIND_OP, csl_pkg::OP_STAR, 16'd1, at);
            "<":     note_token(csl_pkg::KIND_OP, csl_pkg::OP_LESS, 16'd1, at);
            ">":     note_token(csl_pkg::KIND_OP, csl_pkg::OP_GREAT, 16'd1, at);
            "(":     note_token(csl_pkg::KIND_SEP, csl_pkg::SEP_LPAREN, 16'd1, at);
            ")":     note_token(csl_pkg::KIND_SEP, csl_pkg::SEP_RPAREN, 16'd1, at);
            "{":     note_token(csl_pkg::KIND_SEP, csl_pkg::SEP_LBRACE, 16'd1, at);
            "}":     note_token(csl_pkg::KIND_SEP, csl_pkg::SEP_RBRACE, 16'd1, at);
            ";":     note_token(csl_pkg::KIND_SEP, csl_pkg::SEP_SEMI, 16'd1, at);
            ",":     note_token(csl_pkg::KIND_SEP, csl_pkg::SEP_COMMA, 16'd1, at);
            default: note_token(csl_pkg::KIND_UNKNOWN, csl_pkg::CODE_NONE, 16'd1, at);
        endcase
    endfunction

    // end of input: whatever is open goes out as it stands
    function automatic void flush_open();
        case (scan_state)
            csl_pkg::MODE_IDENT:
                close_word();
            csl_pkg::MODE_NUM_INT, csl_pkg::MODE_NUM_FRAC:
                note_token(csl_pkg::KIND_NUMBER, csl_pkg::CODE_NONE, tok_len, tok_start);
            csl_pkg::MODE_NUM_DOT:
            begin
                note_token(csl_pkg::KIND_NUMBER, csl_pkg::CODE_NONE, tok_len, tok_start);
                note_token(csl_pkg::KIND_UNKNOWN, csl_pkg::CODE_NONE, 16'd1,
                           byte_pos - 32'd1);
            end
            csl_pkg::MODE_SLASH:
                note_token(csl_pkg::KIND_OP, csl_pkg::OP_SLASH, 16'd1, tok_start);
            csl_pkg::MODE_EQ:
                note_token(csl_pkg::KIND_OP, csl_pkg::OP_ASSIGN, 16'd1, tok_start);
            csl_pkg::MODE_LINE_C, csl_pkg::MODE_BLOCK_C:
                note_token(csl_pkg::KIND_COMMENT, csl_pkg::CODE_NONE, tok_len, tok_start);
            default:
            begin
            end
        endcase
    endfunction

    // one accepted transaction in, its records appended to the store
    function automatic void lex_byte(logic [7:0] c, logic fin);
        logic [31:0] at;
        bit          redo;
        at   = byte_pos;
        redo = 1'b0;
        run_recs.delete();
        if (fin)
        begin
            flush_open();
            note_token(csl_pkg::KIND_END, csl_pkg::CODE_NONE, 16'd0, byte_pos);
            reset_scanner();
        end
        else
        begin
            case (scan_state)
                csl_pkg::MODE_IDENT:
                begin
                    if (letter_char(c) || digit_char(c))
                    begin
                        if (tok_len < 16'd6)
                            word_buf = {word_buf[39:0], c};
                        else
                            word_long = 1'b1;
                        bump_len();
                    end
                    else
                    begin
                        close_word();
                        redo = 1'b1;
                    end
                end
                csl_pkg::MODE_NUM_INT:
                begin
                    if (digit_char(c))
                        bump_len();
                    else if (c == ".")
                        scan_state = csl_pkg::MODE_NUM_DOT;
                    else
                    begin
                        note_token(csl_pkg::KIND_NUMBER, csl_pkg::CODE_NONE, tok_len,
                                   tok_start);
                        redo = 1'b1;
                    end
                end
                csl_pkg::MODE_NUM_DOT:
                begin
                    // the dot only joins the number when a digit follows
                    if (digit_char(c))
                    begin
                        bump_len();
                        bump_len();
                        scan_state = csl_pkg::MODE_NUM_FRAC;
                    end
                    else
                    begin
                        note_token(csl_pkg::KIND_NUMBER, csl_pkg::CODE_NONE, tok_len,
                                   tok_start);
                        note_token(csl_pkg::KIND_UNKNOWN, csl_pkg::CODE_NONE, 16'd1,
                                   at - 32'd1);
                        redo = 1'b1;
                    end
                end
                csl_pkg::MODE_NUM_FRAC:
                begin
                    if (digit_char(c))
                        bump_len();
                    else
                    begin
                        note_token(csl_pkg::KIND_NUMBER, csl_pkg::CODE_NONE, tok_len,
                                   tok_start);
                        redo = 1'b1;
                    end
                end
                csl_pkg::MODE_SLASH:
                begin
                    if (c == "/")
                    begin
                        bump_len();
                        scan_state = csl_pkg::MODE_LINE_C;
                    end
                    else if (c == "*")
                    begin
                        bump_len();
                        star_pending = 1'b0;
                        scan_state   = csl_pkg::MODE_BLOCK_C;
                    end
                    else
                    begin
                        note_token(csl_pkg::KIND_OP, csl_pkg::OP_SLASH, 16'd1, tok_start);
                        redo = 1'b1;
                    end
                end
                csl_pkg::MODE_EQ:
                begin
                    if (c == "=")
                    begin
                        note_token(csl_pkg::KIND_OP, csl_pkg::OP_EQUAL, 16'd2, tok_start);
                        scan_state = csl_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        note_token(csl_pkg::KIND_OP, csl_pkg::OP_ASSIGN, 16'd1, tok_start);
                        redo = 1'b1;
                    end
                end
                csl_pkg::MODE_LINE_C:
                begin
                    // newline closes the comment and is then handled on its own
                    if (c == CH_LF)
                    begin
                        note_token(csl_pkg::KIND_COMMENT, csl_pkg::CODE_NONE, tok_len,
                                   tok_start);
                        redo = 1'b1;
                    end
                    else
                        bump_len();
                end
                csl_pkg::MODE_BLOCK_C:
                begin
                    bump_len();
                    if (c == "/" && star_pending)
                    begin
                        note_token(csl_pkg::KIND_COMMENT, csl_pkg::CODE_NONE, tok_len,
                                   tok_start);
                        scan_state   = csl_pkg::MODE_IDLE;
                        star_pending = 1'b0;
                    end
                    else
                    begin
                        if (c == CH_LF)
                            bump_line();
                        star_pending = (c == "*");
                    end
                end
                default:
                    redo = 1'b1;
            endcase
            if (redo)
                fresh_byte(c, at);
            byte_pos = at + 32'd1;
        end
        if (run_recs.size() != 0)
            run_recs[run_recs.size() - 1].last = 1'b1;
        foreach (run_recs[i])
            token_store.insert(token_store.size(), run_recs[i]);
    endfunction

    // ------------------------------------------------------------------------
    // mismatch reporting, printing capped so a broken core cannot flood the log
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, longint unsigned got,
                                   longint unsigned want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] record %0d: %s, got %0h expected %0h",
                     $time, records_seen, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // driver: presents the next byte; a held transaction stays until accepted
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && (!push || !full))
        begin
            if (source_q.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                next_src = source_q.pop_front();
                push      <= 1'b1;
                char_byte <= next_src.ch;
                end_mark  <= next_src.fin;
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks the popped record first, then predicts the accepted byte,
    // so the store never depends on event order inside one edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (token_store.size() == 0)
                begin
                    report_mismatch("record with nothing expected", token_kind, 0);
                end
                else
                begin
                    want_rec = token_store.pop_front();
                    if (token_kind !== want_rec.kind)
                        report_mismatch("token_kind", token_kind, want_rec.kind);
                    if (token_code !== want_rec.code)
                        report_mismatch("token_code", token_code, want_rec.code);
                    if (token_length !== want_rec.len)
                        report_mismatch("token_length", token_length, want_rec.len);
                    if (start_offset !== want_rec.offset)
                        report_mismatch("start_offset", start_offset, want_rec.offset);
                    if (line_number !== want_rec.line)
                        report_mismatch("line_number", line_number, want_rec.line);
                    if (last_of_run !== want_rec.last)
                        report_mismatch("last_of_run", last_of_run, want_rec.last);
                end
                records_seen <= records_seen + 1;
            end
            if (push && !full)
            begin
                lex_byte(char_byte, end_mark);
                bytes_taken <= bytes_taken + 1;
            end
            // receiver idles at random, and all the time during the hold-off
            pop <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // long receiver hold-off, once, while the sender keeps offering bytes;
    // the core has to fill up and raise full
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && bytes_taken >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // ------------------------------------------------------------------------
    // source text builders
    // ------------------------------------------------------------------------
    task automatic queue_byte(logic [7:0] b);
        src_byte_t s;
        s.ch  = b;
        s.fin = 1'b0;
        source_q.insert(source_q.size(), s);
    endtask

    task automatic queue_text(string t);
        for (int i = 0; i < t.len(); i++)
            queue_byte(t[i]);
    endtask

    // the byte that rides with the end marker is ignored, so make it random
    task automatic queue_end();
        src_byte_t s;
        s.ch  = 8'($urandom_range(255));
        s.fin = 1'b1;
        source_q.insert(source_q.size(), s);
    endtask

    function automatic logic [7:0] word_char(bit first);
        int r;
        r = $urandom_range(first ? 52 : 62);
        if (r < 26)
            return 8'("a" + r);
        else if (r < 52)
            return 8'("A" + r - 26);
        else if (r == 52)
            return "_";
        else
            return 8'("0" + r - 53);
    endfunction

    // mostly well-formed lexemes glued back to back, plus noise and end markers
    task automatic queue_fragment();
        int    pick;
        int    n;
        string ops;
        string seps;
        string blk;
        ops  = "+-*/=<>";
        seps = "(){};,";
        blk  = "*\na /";
        pick = $urandom_range(99);
        if (pick < 12)
        begin
            queue_text(kw_words[$urandom_range(5)]);
        end
        else if (pick < 24)
        begin
            // plain word, or a keyword with a tail that spoils it
            if ($urandom_range(3) == 0)
            begin
                queue_text(kw_words[$urandom_range(5)]);
                n = $urandom_range(3, 1);
            end
            else
            begin
                queue_byte(word_char(1'b1));
                n = $urandom_range(8);
            end
            repeat (n) queue_byte(word_char(1'b0));
        end
        else if (pick < 36)
        begin
            repeat ($urandom_range(3, 1)) queue_byte(8'("0" + $urandom_range(9)));
            n = $urandom_range(99);
            if (n < 40)
            begin
                queue_byte(".");
                repeat ($urandom_range(3, 1)) queue_byte(8'("0" + $urandom_range(9)));
            end
            else if (n < 55)
            begin
                queue_byte(".");  // dangling dot, whatever follows decides
            end
        end
        else if (pick < 48)
        begin
            if ($urandom_range(4) == 0)
                queue_text("==");
            else
                queue_byte(ops[$urandom_range(6)]);
        end
        else if (pick < 58)
        begin
            queue_byte(seps[$urandom_range(5)]);
        end
        else if (pick < 64)
        begin
            queue_text("//");
            repeat ($urandom_range(6)) queue_byte(8'($urandom_range(126, 32)));
            queue_byte(CH_LF);
        end
        else if (pick < 71)
        begin
            queue_text("/*");
            repeat ($urandom_range(6)) queue_byte(blk[$urandom_range(4)]);
            queue_text("*/");
        end
        else if (pick < 83)
        begin
            case ($urandom_range(3))
                0:       queue_byte(CH_SPACE);
                1:       queue_byte(CH_TAB);
                2:       queue_byte(CH_CR);
                default: queue_byte(CH_LF);
            endcase
        end
        else if (pick < 89)
        begin
            case ($urandom_range(3))
                0:       queue_byte(".");
                1:       queue_byte("#");
                2:       queue_byte(8'h00);
                default: queue_byte(8'($urandom_range(255, 128)));
            endcase
        end
        else if (pick < 97)
        begin
            queue_byte(8'($urandom_range(255)));
        end
        else
        begin
            queue_end();
        end
    endtask

    task automatic queue_random(int count);
        int base;
        base = source_q.size();
        while (source_q.size() - base < count)
            queue_fragment();
    endtask

    // wait until the driver has nothing left, optionally also every record
    task automatic settle(bit with_results);
        do
            @(negedge clk);
        while ((source_q.size() != 0 || push || (with_results && token_store.size() != 0))
               && cycle_cnt < CYCLE_LIMIT);
    endtask

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        reset_scanner();

        // directed: dot without digit, nul and high bytes, both comment kinds with
        // a newline, and open tokens cut off by the end marker
        queue_text("7.x");
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_text("//c\n");
        queue_text("/*\n*/");
        queue_text("a=");
        queue_end();
        queue_text("3.");
        queue_end();
        queue_byte("/");
        queue_end();
        queue_text("/*");
        queue_end();

        // first phase: sender idles a little, receiver a lot
        queue_random(RANDOM_PER_PHASE);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        settle(1'b0);

        // second phase: the other way round
        tx_idle_pct = 67;
        rx_idle_pct = 22;
        queue_random(RANDOM_PER_PHASE);
        settle(1'b0);

        // last phase: no idling
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        queue_random(RANDOM_PER_PHASE);
        queue_end();
        settle(1'b1);

        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            report_mismatch("cycle limit reached", cycle_cnt, CYCLE_LIMIT);
            $display("CHECK FAILED");
        end
        else
        begin
            repeat (DRAIN_CYCLES) @(negedge clk);
            if (token_store.size() != 0)
                report_mismatch("records never delivered", token_store.size(), 0);
            if (mismatches == 0)
                $display("CHECK OK");
            else
                $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
